>>> rtl/rvn_pkg.sv
package rvn_pkg;

  typedef struct packed {
    logic signed [15:0] sample;
    logic signed [15:0] gain;
    logic               final_element;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] normalized;
    logic [5:0]         position;
    logic               end_of_run;
    logic               overflowed;
  } out_item_t;

  localparam int unsigned SUM_W = 38;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned PROD_W = 32;
  localparam logic [15:0] EPS_RESET = 16'd1;
  localparam logic [0:0] REG_EPSILON = 1'b0;

endpackage

>>> rtl/rms_vector_normalizer.sv
// Channel | Direction | Handshake        | Payload
// in      | input     | start, busy      | in_item   (rvn_pkg::in_item_t)
// out     | output    | out_valid strobe | out_item  (rvn_pkg::out_item_t)
// cfg     | input     | APB psel/penable | epsilon at byte address 0
// Loading takes one cycle per element; busy stays low between loads.
// The final element starts a divide, a square root and a reciprocal in one
// shared bit-serial unit. After that, S_MUL issues the first RAM read, and the
// read data, the product register and the output register follow; then one
// result leaves per cycle. Busy drops in the cycle that carries the last result.
// Reset is synchronous; results cannot be stalled by the receiver.
module rms_vector_normalizer #(
  parameter int unsigned DIM = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rvn_pkg::in_item_t   in_item,
  output logic                out_valid,
  output rvn_pkg::out_item_t  out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned AW = 6;
  localparam int unsigned PW = rvn_pkg::PROD_W;

  typedef enum logic [5:0] {
    S_LOAD = 6'b000001,
    S_DIV  = 6'b000010,
    S_SQRT = 6'b000100,
    S_RCP  = 6'b001000,
    S_MUL  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [15:0] eps_r;
  logic [rvn_pkg::SUM_W-1:0] sum_r;
  logic [rvn_pkg::CNT_W-1:0] cnt_r;
  logic ovf_r;
  logic [63:0] rem_r;
  logic [63:0] quo_r;
  logic [63:0] root_r;
  logic [5:0]  step_r;
  logic [32:0] fac_r;
  logic [AW:0] idx_r;
  logic        rd_vld_r;
  logic [AW:0] rd_idx_r;
  logic [PW-1:0] prod_mag_r;
  logic        prod_neg_r;
  logic        mul_vld_r;
  logic [AW:0] mul_idx_r;

  logic accept;
  logic cfg_wr;
  logic [31:0] prod;
  logic [PW-1:0] rd_data;
  logic [31:0] sq;
  logic wr_en;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == rvn_pkg::REG_EPSILON) ? {16'd0, eps_r} : 32'd0;
  assign busy = (state_r != S_LOAD);
  assign accept = start && !busy;
  assign prod = 32'($signed(in_item.sample) * $signed(in_item.gain));
  assign sq = 32'($signed(in_item.sample) * $signed(in_item.sample));
  assign wr_en = accept && (cnt_r < rvn_pkg::CNT_W'(DIM));

  rvn_ram #(.WIDTH(PW), .DEPTH(64)) u_store (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(cnt_r[AW-1:0]),
    .wr_data(prod),
    .rd_addr(idx_r[AW-1:0]),
    .rd_data(rd_data)
  );

  // Shared shift-subtract datapath.
  logic [64:0] div_trial;
  logic [63:0] div_rem_sh;
  logic [63:0] sq_rem_sh;
  logic [65:0] sq_trial;
  logic [63:0] sq_src;
  logic [63:0] m_val;
  assign div_rem_sh = {rem_r[62:0], quo_r[63]};
  assign div_trial = {1'b0, div_rem_sh} - {1'b0, root_r};
  assign sq_src = quo_r;
  assign sq_rem_sh = {rem_r[61:0], sq_src[63:62]};
  assign sq_trial = {2'b0, sq_rem_sh} - {2'b0, root_r[61:0], 2'b01};
  assign m_val = {quo_r[62:0], !div_trial[64]} + {32'd0, eps_r, 16'd0};

  // Magnitude times factor, rounded by adding half an LSB.
  logic [64:0] scaled;
  assign scaled = 65'(prod_mag_r) * 65'(fac_r) + 65'(64'd1 << 27);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: if (accept && in_item.final_element) begin
        state_nxt = S_DIV;
      end
      S_DIV:  if (step_r == 6'd63) state_nxt = S_SQRT;
      S_SQRT: if (step_r == 6'd31) state_nxt = S_RCP;
      S_RCP:  if (step_r == 6'd40) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_EMIT;
      S_EMIT: if (mul_vld_r && (mul_idx_r + 1'b1 == {1'b0, cnt_r[AW-1:0]} ||
                  (mul_idx_r + 1'b1) == cnt_r)) state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      eps_r <= rvn_pkg::EPS_RESET;
      sum_r <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      step_r <= '0;
      idx_r <= '0;
      rd_vld_r <= 1'b0;
      mul_vld_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && paddr[2] == rvn_pkg::REG_EPSILON) eps_r <= pwdata[15:0];
      out_valid <= 1'b0;
      rd_vld_r <= 1'b0;
      mul_vld_r <= 1'b0;
      case (state_r)
        S_LOAD: begin
          step_r <= '0;
          idx_r <= '0;
          if (accept) begin
            if (wr_en) begin
              sum_r <= sum_r + rvn_pkg::SUM_W'(sq);
              cnt_r <= cnt_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_item.final_element) begin
              // dividend sum*2^16 in quo_r, divisor count in root_r
              quo_r <= {10'd0, (wr_en ? sum_r + rvn_pkg::SUM_W'(sq) : sum_r), 16'd0};
              root_r <= {57'd0, (wr_en ? cnt_r + 1'b1 : cnt_r)};
              rem_r <= '0;
            end
          end
        end
        S_DIV: begin
          step_r <= step_r + 1'b1;
          if (!div_trial[64]) begin
            rem_r <= div_trial[63:0];
            quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= div_rem_sh;
            quo_r <= {quo_r[62:0], 1'b0};
          end
          if (step_r == 6'd63) begin
            step_r <= '0;
            quo_r <= {m_val[47:0], 16'd0};
            rem_r <= '0;
            root_r <= '0;
            fac_r <= (m_val == '0) ? 33'h1_0000_0000 : 33'd0;
          end
        end
        S_SQRT: begin
          step_r <= step_r + 1'b1;
          quo_r <= {quo_r[61:0], 2'b00};
          if (!sq_trial[65]) begin
            rem_r <= sq_trial[63:0];
            root_r <= {root_r[62:0], 1'b1};
          end else begin
            rem_r <= sq_rem_sh;
            root_r <= {root_r[62:0], 1'b0};
          end
          if (step_r == 6'd31) begin
            step_r <= '0;
            rem_r <= '0;
            quo_r <= 64'h0000_0100_0000_0000 << 23;
          end
        end
        S_RCP: begin
          step_r <= step_r + 1'b1;
          if (fac_r == 33'h1_0000_0000) begin
            // zero mean square plus epsilon keeps the preset factor
          end else if (!div_trial[64]) begin
            rem_r <= div_trial[63:0];
            quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= div_rem_sh;
            quo_r <= {quo_r[62:0], 1'b0};
          end
          if (step_r == 6'd40 && fac_r != 33'h1_0000_0000) begin
            fac_r <= {quo_r[31:0], !div_trial[64]};
          end
        end
        S_MUL: begin
          idx_r <= idx_r + 1'b1;
          rd_vld_r <= 1'b1;
          rd_idx_r <= idx_r;
        end
        S_EMIT: begin
          if (idx_r < {1'b0, cnt_r[AW-1:0]} || (idx_r < cnt_r && cnt_r[AW])) begin
            idx_r <= idx_r + 1'b1;
            rd_vld_r <= 1'b1;
            rd_idx_r <= idx_r;
          end
          mul_vld_r <= rd_vld_r;
          mul_idx_r <= rd_idx_r;
          prod_neg_r <= rd_data[PW-1];
          prod_mag_r <= rd_data[PW-1] ? PW'(-rd_data) : rd_data;
          if (mul_vld_r) begin
            out_valid <= 1'b1;
            out_item.position <= mul_idx_r[AW-1:0];
            out_item.end_of_run <= (mul_idx_r + 1'b1) == cnt_r;
            out_item.overflowed <= ovf_r;
            if (prod_neg_r) begin
              out_item.normalized <= (scaled[64:28] > 37'd32768) ? 16'sh8000 :
                                     16'(-scaled[43:28]);
            end else begin
              out_item.normalized <= (scaled[64:28] > 37'd32767) ? 16'sh7fff :
                                     16'(scaled[43:28]);
            end
            if ((mul_idx_r + 1'b1) == cnt_r) begin
              sum_r <= '0;
              cnt_r <= '0;
              ovf_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_EMIT)
    else $error("result outside emit phase");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.end_of_run) |-> {1'b0, out_item.position} < cnt_r)
    else $error("position beyond stored count");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> cnt_r <= rvn_pkg::CNT_W'(DIM))
    else $error("count above capacity");

endmodule

>>> rtl/rvn_ram.sv
module rvn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
